@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MMCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define MMCT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hdl/mmct_pkg.sv @@
package mmct_pkg;

  localparam int RAW_W   = 10;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 7;
  localparam int IVL_W   = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_CAP   = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_CLAMP = 7'd99;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADOPT_WINDOW     = 2'd2;

  localparam logic [IVL_W-1:0]   RST_MEASURE_INTERVAL = 16'd100;
  localparam logic [LEVEL_W-1:0] RST_MIN_CHANGE       = 7'd5;
  localparam logic [TIME_W-1:0]  RST_ADOPT_WINDOW     = 32'd1800000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic               taken;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  now_ms;
  } queue_entry_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_change;
    logic [TIME_W-1:0]  adopt_window;
  } back_cfg_t;

endpackage

@@ hdl/mmct_ram.sv @@
module mmct_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/mmct_front.sv @@
module mmct_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mmct_pkg::RAW_W-1:0]    in_raw_sample,
  input  logic [mmct_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [mmct_pkg::IVL_W-1:0]    measure_interval,
  input  logic                          q_full,
  output logic                          q_push,
  output mmct_pkg::queue_entry_t        q_data
);
  import mmct_pkg::*;

  logic [TIME_W-1:0]  last_r;
  logic [TIME_W-1:0]  elapsed;
  logic [RAW_W-1:0]   inv_raw;
  logic [LEVEL_W-1:0] lvl_raw;
  logic               taken;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    // wraps modulo 2^32, so a step back in time reads as a long gap
    elapsed = in_now_ms - last_r;
    taken   = elapsed >= {{(TIME_W-IVL_W){1'b0}}, measure_interval};
    // 1023 - raw is the bitwise inverse of a 10-bit value
    inv_raw = ~in_raw_sample;
    lvl_raw = inv_raw[RAW_W-1:3];
    q_data.taken  = taken;
    q_data.level  = (lvl_raw > LEVEL_CAP) ? LEVEL_CLAMP : lvl_raw;
    q_data.now_ms = in_now_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (q_push && taken) begin
      last_r <= in_now_ms;
    end
  end

endmodule

@@ hdl/mmct_fifo.sv @@
module mmct_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  mmct_pkg::queue_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output mmct_pkg::queue_entry_t pop_data,
  output logic                   empty
);
  import mmct_pkg::*;

  localparam logic [QUEUE_AW:0] CNT_FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);

  queue_entry_t        mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign full     = count_r == CNT_FULL;
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

@@ hdl/mmct_back.sv @@
module mmct_back #(
  parameter int BATCH_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmct_pkg::back_cfg_t            cfg,
  input  logic                           q_empty,
  input  mmct_pkg::queue_entry_t         q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_sample_taken,
  output logic                           out_changed,
  output logic                           out_increased,
  output logic [mmct_pkg::LEVEL_W-1:0]   out_level,
  output logic [mmct_pkg::LEVEL_W-1:0]   out_max_level
);
  import mmct_pkg::*;

  localparam int AW = $clog2(BATCH_SIZE);
  localparam int CW = $clog2(BATCH_SIZE + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(BATCH_SIZE - 1);
  localparam logic [CW-1:0] RANK     = CW'(BATCH_SIZE / 2 + 1);
  localparam logic [2:0]    TOP_BIT  = 3'(LEVEL_W - 1);
  localparam logic [LEVEL_W-1:0] ALL_ONES = '1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SELECT = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]         state_r;
  logic [AW-1:0]      fill_r;
  logic [LEVEL_W-1:0] held_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [TIME_W-1:0]  rise_time_r;
  logic [TIME_W-1:0]  now_r;
  logic [AW-1:0]      sel_addr_r;
  logic               issue_done_r;
  logic               rd_vld_r;
  logic               rd_last_r;
  logic [2:0]         bit_r;
  logic [LEVEL_W-1:0] prefix_r;
  logic [CW-1:0]      rank_r;
  logic [CW-1:0]      cnt_r;
  logic               chg_r;
  logic               inc_r;

  logic               out_valid_r;
  logic               out_taken_r;
  logic               out_chg_r;
  logic               out_inc_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_max_r;

  logic               out_free;
  logic               out_load;
  logic               issuing;
  logic               ram_we;
  logic [LEVEL_W-1:0] rd_data;
  logic [LEVEL_W-1:0] hi_mask;
  logic               hit;
  logic [CW-1:0]      cnt_sum;
  logic               pass_low;
  logic [LEVEL_W-1:0] diff;
  logic               big_enough;
  logic               rise;
  logic               in_window;

  mmct_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(BATCH_SIZE)
  ) u_batch_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(fill_r),
    .wr_data(q_data.level),
    .rd_addr(sel_addr_r),
    .rd_data(rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty && out_free;
  assign ram_we   = q_pop && q_data.taken;
  assign issuing  = (state_r == ST_SELECT) && !issue_done_r;
  // output register loads on a pass-through transaction or at the end of a batch
  assign out_load = (q_pop && !(q_data.taken && (fill_r == LAST_IDX))) ||
                    ((state_r == ST_EMIT) && out_free);

  // bitwise rank search: count entries matching the known upper bits with a zero here
  always_comb begin
    hi_mask  = (ALL_ONES << bit_r) << 1;
    hit      = rd_vld_r && (((rd_data ^ prefix_r) & hi_mask) == '0) && !rd_data[bit_r];
    cnt_sum  = cnt_r + CW'(hit);
    pass_low = rank_r < cnt_sum;
  end

  always_comb begin
    diff       = (prefix_r >= held_r) ? (prefix_r - held_r) : (held_r - prefix_r);
    big_enough = diff >= cfg.min_change;
    rise       = {1'b0, prefix_r} > ({1'b0, held_r} + {1'b0, cfg.min_change});
    in_window  = (now_r - rise_time_r) < cfg.adopt_window;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      held_r       <= '0;
      peak_r       <= '0;
      rise_time_r  <= '0;
      issue_done_r <= 1'b1;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      bit_r        <= TOP_BIT;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r  <= issuing;
      rd_last_r <= issuing && (sel_addr_r == LAST_IDX);

      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_data.taken && (fill_r == LAST_IDX)) begin
              fill_r       <= '0;
              now_r        <= q_data.now_ms;
              sel_addr_r   <= '0;
              issue_done_r <= 1'b0;
              bit_r        <= TOP_BIT;
              prefix_r     <= '0;
              rank_r       <= RANK;
              cnt_r        <= '0;
              state_r      <= ST_SELECT;
            end else begin
              if (q_data.taken) begin
                fill_r <= fill_r + AW'(1);
              end
              out_taken_r <= q_data.taken;
              out_chg_r   <= 1'b0;
              out_inc_r   <= 1'b0;
              out_level_r <= held_r;
              out_max_r   <= peak_r;
            end
          end
        end

        ST_SELECT: begin
          if (issuing) begin
            sel_addr_r <= sel_addr_r + AW'(1);
            if (sel_addr_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end
          end
          if (rd_last_r) begin
            if (!pass_low) begin
              rank_r          <= rank_r - cnt_sum;
              prefix_r[bit_r] <= 1'b1;
            end
            cnt_r <= '0;
            if (bit_r == '0) begin
              state_r <= ST_DECIDE;
            end else begin
              bit_r        <= bit_r - 3'd1;
              sel_addr_r   <= '0;
              issue_done_r <= 1'b0;
            end
          end else begin
            cnt_r <= cnt_sum;
          end
        end

        ST_DECIDE: begin
          chg_r <= big_enough;
          inc_r <= big_enough && rise;
          if (big_enough) begin
            held_r <= prefix_r;
            if (rise) begin
              peak_r      <= prefix_r;
              rise_time_r <= now_r;
            end else if (in_window || (prefix_r > peak_r)) begin
              peak_r <= prefix_r;
            end
          end
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_taken_r <= 1'b1;
            out_chg_r   <= chg_r;
            out_inc_r   <= inc_r;
            out_level_r <= held_r;
            out_max_r   <= peak_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_taken = out_taken_r;
  assign out_changed      = out_chg_r;
  assign out_increased    = out_inc_r;
  assign out_level        = out_level_r;
  assign out_max_level    = out_max_r;

endmodule

@@ hdl/moisture_median_change_tracker.sv @@
// channel   ports                                   direction
// in        in_valid, in_stall, in_raw_sample,       sample in
//           in_now_ms
// out       out_valid, out_stall, out_sample_taken,  result out
//           out_changed, out_increased, out_level,
//           out_max_level
// cfg       cfg_we, cfg_index, cfg_wdata             register write
//
// a sample that does not close a batch leaves the queue and is loaded into the output register at the same edge
// a batch-closing sample's level is the entry at sorted index BATCH_SIZE/2 + 1, found bit by bit,
// one pass over the batch ram per level bit, one entry read a cycle
// reset is synchronous and needs no clearing pass; the batch ram is only read once fully written
// a 4-entry queue keeps taking samples while the back end searches or the output is stalled, until it fills
module moisture_median_change_tracker #(
  parameter int BATCH_SIZE = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mmct_pkg::RAW_W-1:0]        in_raw_sample,
  input  logic [mmct_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_sample_taken,
  output logic                              out_changed,
  output logic                              out_increased,
  output logic [mmct_pkg::LEVEL_W-1:0]      out_level,
  output logic [mmct_pkg::LEVEL_W-1:0]      out_max_level,
  input  logic                              cfg_we,
  input  logic [mmct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmct_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mmct_pkg::*;

  logic [IVL_W-1:0]   measure_interval_r;
  logic [LEVEL_W-1:0] min_change_r;
  logic [TIME_W-1:0]  adopt_window_r;

  back_cfg_t    back_cfg;
  queue_entry_t push_data;
  queue_entry_t pop_data;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_interval_r <= RST_MEASURE_INTERVAL;
      min_change_r       <= RST_MIN_CHANGE;
      adopt_window_r     <= RST_ADOPT_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEASURE_INTERVAL: measure_interval_r <= cfg_wdata[IVL_W-1:0];
        CFG_MIN_CHANGE:       min_change_r       <= cfg_wdata[LEVEL_W-1:0];
        CFG_ADOPT_WINDOW:     adopt_window_r     <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.min_change   = min_change_r;
  assign back_cfg.adopt_window = adopt_window_r;

  mmct_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_sample   (in_raw_sample),
    .in_now_ms       (in_now_ms),
    .measure_interval(measure_interval_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (push_data)
  );

  mmct_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  mmct_back #(
    .BATCH_SIZE(BATCH_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (back_cfg),
    .q_empty         (q_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_taken(out_sample_taken),
    .out_changed     (out_changed),
    .out_increased   (out_increased),
    .out_level       (out_level),
    .out_max_level   (out_max_level)
  );

endmodule

@@ hdl/mmct_checker.sv @@
`include "assert_macros.svh"

module mmct_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_sample_taken,
  input logic                          out_changed,
  input logic                          out_increased,
  input logic [mmct_pkg::LEVEL_W-1:0]  out_level,
  input logic [mmct_pkg::LEVEL_W-1:0]  out_max_level
);
  import mmct_pkg::*;

  `MMCT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_level) && $stable(out_max_level) && $stable(out_changed), "stalled result moved")
  `MMCT_NEVER(a_flags_need_take, out_valid && !out_sample_taken && (out_changed || out_increased), "change flagged on an ignored sample")
  `MMCT_NEVER(a_rise_is_change, out_valid && out_increased && !out_changed, "rise without change")
  `MMCT_ASSERT(a_rise_sets_peak, out_valid && out_increased |-> out_max_level == out_level, "rise did not move the peak")
  `MMCT_ASSERT(a_level_range, out_valid |-> (out_level <= LEVEL_CAP) && (out_max_level <= LEVEL_CAP), "level out of range")

endmodule

bind moisture_median_change_tracker mmct_checker u_checker (.*);

@@ dv/moisture_tracker_check.sv @@
`timescale 1ns / 1ps

module moisture_tracker_check #(
  parameter int BATCH_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mmct_pkg::RAW_W-1:0]    in_raw_sample,
  input  logic [mmct_pkg::TIME_W-1:0]   in_now_ms,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_sample_taken,
  input  logic                          out_changed,
  input  logic                          out_increased,
  input  logic [mmct_pkg::LEVEL_W-1:0]  out_level,
  input  logic [mmct_pkg::LEVEL_W-1:0]  out_max_level,
  input  logic                          cfg_we,
  input  logic [mmct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import mmct_pkg::*;

  typedef struct packed {
    logic               taken;
    logic               changed;
    logic               increased;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] max_level;
  } reading_result_t;

  // register copies
  logic [IVL_W-1:0]   interval_ms;
  logic [LEVEL_W-1:0] change_min;
  logic [TIME_W-1:0]  window_ms;

  // tracker state
  logic [LEVEL_W-1:0] batch_levels [BATCH_SIZE];
  int unsigned        fill;
  logic [LEVEL_W-1:0] held;
  logic [LEVEL_W-1:0] peak;
  logic [TIME_W-1:0]  last_take;
  logic [TIME_W-1:0]  last_rise;

  reading_result_t    expected_readings [$];
  int                 results_seen;

  function automatic logic [LEVEL_W-1:0] moisture_level(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] dryness;
    logic [RAW_W-1:0] lvl;
    dryness = 10'd1023 - raw;
    lvl = dryness / 10'd8;
    if (lvl > RAW_W'(LEVEL_CAP)) begin
      lvl = RAW_W'(LEVEL_CLAMP);
    end
    return lvl[LEVEL_W-1:0];
  endfunction

  // sorted entry at index BATCH_SIZE/2 + 1 of the full batch, one above the upper middle
  function automatic logic [LEVEL_W-1:0] batch_median();
    logic [LEVEL_W-1:0] sorted [BATCH_SIZE];
    logic [LEVEL_W-1:0] key;
    int j;
    sorted = batch_levels;
    for (int i = 1; i < BATCH_SIZE; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = key;
    end
    return sorted[BATCH_SIZE/2 + 1];
  endfunction

  task automatic take_reading(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] now,
                              output reading_result_t res);
    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] cand;
    int                 diff;
    res = '0;
    elapsed = now - last_take;
    if (elapsed >= TIME_W'(interval_ms)) begin
      res.taken = 1'b1;
      last_take = now;
      if (fill >= BATCH_SIZE) begin
        fill = 0;
      end
      batch_levels[fill] = moisture_level(raw);
      fill++;
      if (fill >= BATCH_SIZE) begin
        cand = batch_median();
        fill = 0;
        diff = (cand >= held) ? int'(cand) - int'(held) : int'(held) - int'(cand);
        if (diff >= int'(change_min)) begin
          res.changed = 1'b1;
          if (int'(cand) > int'(held) + int'(change_min)) begin
            res.increased = 1'b1;
            peak = cand;
            last_rise = now;
          end else if (TIME_W'(now - last_rise) < window_ms) begin
            peak = cand;
          end else if (cand > peak) begin
            peak = cand;
          end
          held = cand;
        end
      end
    end
    res.level = held;
    res.max_level = peak;
  endtask

  task automatic note_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: result %0d mismatch: %s", $time, results_seen, what);
    end
  endtask

  always @(posedge clk) begin
    reading_result_t want;
    reading_result_t got;
    if (!rst_n) begin
      interval_ms = RST_MEASURE_INTERVAL;
      change_min  = RST_MIN_CHANGE;
      window_ms   = RST_ADOPT_WINDOW;
      fill = 0;
      held = '0;
      peak = '0;
      last_take = '0;
      last_rise = '0;
      results_seen = 0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEASURE_INTERVAL: interval_ms = cfg_wdata[IVL_W-1:0];
          CFG_MIN_CHANGE:       change_min  = cfg_wdata[LEVEL_W-1:0];
          CFG_ADOPT_WINDOW:     window_ms   = cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_reading(in_raw_sample, in_now_ms, want);
        expected_readings.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.taken     = out_sample_taken;
        got.changed   = out_changed;
        got.increased = out_increased;
        got.level     = out_level;
        got.max_level = out_max_level;
        if (expected_readings.size() == 0) begin
          note_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_readings.pop_front();
          if (got.taken !== want.taken)
            note_mismatch($sformatf("sample_taken %b, want %b", got.taken, want.taken));
          if (got.changed !== want.changed)
            note_mismatch($sformatf("changed %b, want %b", got.changed, want.changed));
          if (got.increased !== want.increased)
            note_mismatch($sformatf("increased %b, want %b", got.increased, want.increased));
          if (got.level !== want.level)
            note_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
          if (got.max_level !== want.max_level)
            note_mismatch($sformatf("max_level %0d, want %0d", got.max_level, want.max_level));
        end
        results_seen++;
      end
    end
    pending = expected_readings.size();
  end

endmodule

@@ dv/tb_moisture_median_change_tracker.sv @@
`timescale 1ns / 1ps

module tb_moisture_median_change_tracker;
  import mmct_pkg::*;

  localparam int BATCH       = 32;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF    = 400;
  localparam int CHUNKS      = 8;
  localparam int CHUNK_ITEMS = 92;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_W-1:0]      in_raw_sample;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_sample_taken;
  logic                  out_changed;
  logic                  out_increased;
  logic [LEVEL_W-1:0]    out_level;
  logic [LEVEL_W-1:0]    out_max_level;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int quiet_cycles;

  logic [TIME_W-1:0] clock_ms;
  logic [IVL_W-1:0]  gap_ms;
  logic [RAW_W-1:0]  target_raw;

  moisture_median_change_tracker #(.BATCH_SIZE(BATCH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_raw_sample(in_raw_sample), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_taken(out_sample_taken), .out_changed(out_changed),
    .out_increased(out_increased), .out_level(out_level), .out_max_level(out_max_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  moisture_tracker_check #(.BATCH_SIZE(BATCH)) u_level_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_raw_sample(in_raw_sample), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_taken(out_sample_taken), .out_changed(out_changed),
    .out_increased(out_increased), .out_level(out_level), .out_max_level(out_max_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[moisture_median_change_tracker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    in_now_ms     <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  // caller lowers cfg_we after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    int chunk;
    int k;
    int pick;
    int jit;
    logic [IVL_W-1:0]   ivl;
    logic [LEVEL_W-1:0] mc;
    logic [TIME_W-1:0]  win;
    logic [RAW_W-1:0]   raw;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_raw_sample <= '0;
    in_now_ms     <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MEASURE_INTERVAL;
    cfg_wdata     <= '0;
    send_idle_pct  = 27;
    recv_stall_pct = 61;
    gap_ms         = RST_MEASURE_INTERVAL;
    target_raw     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: interval edges, clamp boundary, timestamp wrap and a backward step
    offer(10'd1023, 32'd0);
    offer(10'd0,    32'd99);
    offer(10'd0,    32'd100);
    offer(10'd1023, 32'd150);
    offer(10'd215,  32'd200);
    offer(10'd216,  32'd300);
    offer(10'd1023, 32'd400);
    offer(10'd512,  32'hFFFF_FFFF);
    offer(10'd7,    32'h0000_0010);
    offer(10'd1016, 32'h0000_0063);
    offer(10'd300,  32'h0000_0050);
    offer(10'h2AA,  32'h5555_5555);
    offer(10'h155,  32'hAAAA_AAAA);
    clock_ms = 32'hAAAA_AAAA;

    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      settle(10);
      case (chunk)
        0: begin ivl = 16'd0;     mc = 7'd0;   win = 32'hFFFF_FFFF; end
        1: begin ivl = 16'd100;   mc = 7'd5;   win = 32'd1800000;   end
        2: begin ivl = 16'd65535; mc = 7'd100; win = 32'd0;         end
        3: begin ivl = 16'd37;    mc = 7'd127; win = 32'd5000;      end
        4: begin ivl = 16'd0;     mc = 7'd3;   win = 32'd4000;      end
        5: begin ivl = 16'd250;   mc = 7'd10;  win = 32'd0;         end
        6: begin ivl = 16'd0;     mc = 7'd1;   win = 32'd20000;     end
        default: begin
          ivl = 16'($urandom_range(300));
          mc  = 7'($urandom_range(20));
          win = $urandom_range(100000);
        end
      endcase
      // upper bits of the write data carry noise that the block must drop
      write_reg(CFG_MEASURE_INTERVAL, {16'($urandom), ivl});
      write_reg(CFG_MIN_CHANGE, {25'($urandom), mc});
      write_reg(CFG_ADOPT_WINDOW, win);
      cfg_we <= 1'b0;
      gap_ms = ivl;

      if (chunk < 3) begin
        send_idle_pct  = 27;
        recv_stall_pct = 61;
      end else if (chunk < 6) begin
        send_idle_pct  = 61;
        recv_stall_pct = 27;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (chunk == 3) begin
        clock_ms = 32'hFFFF_F000;
      end

      for (k = 0; k < CHUNK_ITEMS; k++) begin
        if (k % 32 == 0) begin
          pick = $urandom_range(5);
          case (pick)
            0:       target_raw = 10'd0;
            1:       target_raw = 10'd1023;
            2:       target_raw = 10'd215;
            default: target_raw = 10'($urandom_range(1023));
          endcase
        end
        pick = $urandom_range(99);
        if (pick < 78) begin
          clock_ms = clock_ms + gap_ms + $urandom_range(40);
        end else if (pick < 88) begin
          // too soon after the previous sample; with a zero interval the time does not move
          if (gap_ms > 0) clock_ms = clock_ms + $urandom_range(gap_ms - 1);
        end else if (pick < 94) begin
          clock_ms = clock_ms - $urandom_range(100000, 1);
        end else begin
          clock_ms = $urandom;
        end
        if ($urandom_range(99) < 85) begin
          jit = int'(target_raw) + int'($urandom_range(32)) - 16;
          if (jit < 0) jit = 0;
          if (jit > 1023) jit = 1023;
          raw = jit[RAW_W-1:0];
        end else begin
          raw = 10'($urandom_range(1023));
        end
        // long receiver hold-off so the queue fills and the input stalls
        if (chunk == 6 && k == 30) begin
          hold_req = HOLD_OFF;
        end
        offer(raw, clock_ms);
      end
    end

    settle(250);
    if (fail_count == 0 && pending == 0) begin
      $display("[moisture_median_change_tracker] OK");
    end else begin
      $display("[moisture_median_change_tracker] ERROR");
    end
    $finish;
  end

endmodule
